### rtl/wcpp_pkg.sv
// Shared types and constants for the waveform column peak plotter.
// No dependencies; imported by every module of the block.
`default_nettype none
package wcpp_pkg;

  localparam int SIDX_BITS    = 24;
  localparam int COL_BITS     = 12;
  localparam int WID_BITS     = 13;
  localparam int MAG_BITS     = 15;
  localparam int SAMPLE_BITS  = 16;
  localparam int PIX_BITS     = 14;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DAT_BITS = 24;
  localparam int MAX_COLUMNS  = 4096;
  localparam int MAX_CHANNELS = 2;
  localparam int DIV_CNT_BITS = $clog2(SIDX_BITS + 1);

  typedef logic [MAG_BITS-1:0] mag_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_SAMPLE_COUNT  = 3'd0,
    CFG_COLUMN_COUNT  = 3'd1,
    CFG_PLOT_HEIGHT   = 3'd2,
    CFG_CENTER_ROW    = 3'd3,
    CFG_ORIGIN_COLUMN = 3'd4,
    CFG_CHANNEL_COUNT = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic                valid;
    mag_t                peak;
    logic [COL_BITS-1:0] col;
    logic                last;
  } emit_t;

endpackage
`default_nettype wire

### rtl/wcpp_lane.sv
// One channel lane: registered saturating magnitude of a Q1.15 sample.
// Depends on wcpp_pkg.
`default_nettype none
module wcpp_lane (
  input  wire logic                             clk,
  input  wire logic                             load,
  input  wire logic                             active,
  input  wire logic signed [wcpp_pkg::SAMPLE_BITS-1:0] sample,
  output wcpp_pkg::mag_t                        mag_r
);
  import wcpp_pkg::*;

  logic [SAMPLE_BITS-1:0] abs_v;
  mag_t                   mag_nxt;

  always_comb begin
    abs_v = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
    if (!active) begin
      mag_nxt = '0;
    end else if (abs_v[SAMPLE_BITS-1]) begin
      mag_nxt = '1;
    end else begin
      mag_nxt = abs_v[MAG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mag_r <= mag_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/wcpp_div.sv
// Restoring divider, one quotient bit per cycle: sample count over column count.
// Depends on wcpp_pkg.
`default_nettype none
module wcpp_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [wcpp_pkg::SIDX_BITS-1:0] dividend,
  input  wire logic [wcpp_pkg::WID_BITS-1:0]  divisor,
  output logic                               busy,
  output logic [wcpp_pkg::SIDX_BITS-1:0]     quo,
  output logic [wcpp_pkg::WID_BITS-1:0]      rem
);
  import wcpp_pkg::*;

  logic [SIDX_BITS-1:0]    quo_r, quo_nxt;
  logic [WID_BITS-1:0]     rem_r, rem_nxt;
  logic [WID_BITS-1:0]     dsr_r, dsr_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [WID_BITS:0]       trial;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    cnt_nxt = cnt_r;
    trial   = {rem_r, quo_r[SIDX_BITS-1]};
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
      cnt_nxt = DIV_CNT_BITS'(SIDX_BITS);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = WID_BITS'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[SIDX_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[WID_BITS-1:0];
        quo_nxt = {quo_r[SIDX_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quo_r <= SIDX_BITS'(1);
      rem_r <= '0;
      dsr_r <= WID_BITS'(1);
      cnt_r <= '0;
    end else begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      dsr_r <= dsr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

### rtl/wcpp_track.sv
// Merge stage: folds lane magnitudes into the running peak, tracks column
// boundaries and holds the finished-column record. Depends on wcpp_pkg.
`default_nettype none
module wcpp_track (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           clear,
  input  wire logic                           step,
  input  wire logic                           e_free,
  input  wire wcpp_pkg::mag_t                 mags [wcpp_pkg::MAX_CHANNELS],
  input  wire logic [wcpp_pkg::SIDX_BITS-1:0] quo,
  input  wire logic [wcpp_pkg::WID_BITS-1:0]  rem,
  input  wire logic [wcpp_pkg::WID_BITS-1:0]  cols,
  output wcpp_pkg::emit_t                     emit_r
);
  import wcpp_pkg::*;

  logic [SIDX_BITS-1:0] sidx_r, sidx_nxt;
  logic [COL_BITS-1:0]  col_r, col_nxt;
  logic [SIDX_BITS-1:0] nb_r, nb_nxt;
  logic [WID_BITS-1:0]  brem_r, brem_nxt;
  mag_t                 peak_r, peak_nxt;
  emit_t                emit_nxt;

  logic                 first;
  logic [SIDX_BITS-1:0] nb_cur, sidx_inc;
  logic [WID_BITS-1:0]  brem_cur;
  logic [WID_BITS:0]    brem_sum;
  mag_t                 pk;
  logic                 hit, last;

  always_comb begin
    first    = (sidx_r == '0) && (col_r == '0);
    nb_cur   = first ? quo : nb_r;
    brem_cur = first ? rem : brem_r;
    pk       = peak_r;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      if (mags[i] > pk) pk = mags[i];
    end
    sidx_inc = sidx_r + 1'b1;
    hit      = (sidx_inc == nb_cur);
    last     = ({1'b0, col_r} + 1'b1) >= cols;
    brem_sum = {1'b0, brem_cur} + {1'b0, rem};

    sidx_nxt = sidx_r;
    col_nxt  = col_r;
    nb_nxt   = nb_r;
    brem_nxt = brem_r;
    peak_nxt = peak_r;
    emit_nxt = emit_r;
    if (e_free) emit_nxt.valid = 1'b0;

    if (clear) begin
      sidx_nxt = '0;
      col_nxt  = '0;
      nb_nxt   = '0;
      brem_nxt = '0;
      peak_nxt = '0;
    end else if (step) begin
      if (!hit) begin
        sidx_nxt = sidx_inc;
        nb_nxt   = nb_cur;
        brem_nxt = brem_cur;
        peak_nxt = pk;
      end else begin
        emit_nxt.valid = 1'b1;
        emit_nxt.peak  = pk;
        emit_nxt.col   = col_r;
        emit_nxt.last  = last;
        peak_nxt       = '0;
        if (last) begin
          sidx_nxt = '0;
          col_nxt  = '0;
          nb_nxt   = '0;
          brem_nxt = '0;
        end else begin
          sidx_nxt = sidx_inc;
          col_nxt  = col_r + 1'b1;
          if (brem_sum >= {1'b0, cols}) begin
            brem_nxt = WID_BITS'(brem_sum - {1'b0, cols});
            nb_nxt   = nb_cur + quo + 1'b1;
          end else begin
            brem_nxt = brem_sum[WID_BITS-1:0];
            nb_nxt   = nb_cur + quo;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sidx_r       <= '0;
      col_r        <= '0;
      nb_r         <= '0;
      brem_r       <= '0;
      peak_r       <= '0;
      emit_r.valid <= 1'b0;
    end else begin
      sidx_r       <= sidx_nxt;
      col_r        <= col_nxt;
      nb_r         <= nb_nxt;
      brem_r       <= brem_nxt;
      peak_r       <= peak_nxt;
      emit_r.valid <= emit_nxt.valid;
    end
    emit_r.peak <= emit_nxt.peak;
    emit_r.col  <= emit_nxt.col;
    emit_r.last <= emit_nxt.last;
  end

endmodule
`default_nettype wire

### rtl/waveform_column_peak_plotter.sv
// Top level of the waveform column peak plotter: configuration registers,
// channel lanes, boundary divider, merge stage and output register.
// Depends on wcpp_pkg, wcpp_lane, wcpp_div and wcpp_track.
//
// Accepts one frame per cycle while in_stall is low and emits one pixel per
// finished column, through the lane register, merge stage and output
// register. After a configuration write to a used index the input stalls
// while the restoring divider forms sample_count / column_count one bit per
// cycle; every such write restarts the clip. cfg_ready is always high.
`default_nettype none
module waveform_column_peak_plotter (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [wcpp_pkg::SAMPLE_BITS-1:0] in_sample_ch0,
  input  wire logic signed [wcpp_pkg::SAMPLE_BITS-1:0] in_sample_ch1,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [wcpp_pkg::PIX_BITS-1:0]      out_pixel_x,
  output logic signed [wcpp_pkg::PIX_BITS-1:0]      out_pixel_y,
  output logic                                      out_last_column,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [wcpp_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [wcpp_pkg::CFG_DAT_BITS-1:0]    cfg_data
);
  import wcpp_pkg::*;

  logic [SIDX_BITS-1:0] samples_r;
  logic [WID_BITS-1:0]  columns_r, height_r;
  logic [WID_BITS-1:0]  center_r, origin_r;
  logic [1:0]           chans_r;
  logic                 cfg_hit, start_r;

  logic [SIDX_BITS-1:0] n_eff;
  logic [WID_BITS-1:0]  w_eff;
  logic [1:0]           ch_eff;

  logic                 div_busy;
  logic [SIDX_BITS-1:0] quo;
  logic [WID_BITS-1:0]  rem;

  logic                 in_acc, l_valid_r, l_free, step;
  logic                 e_free, o_adv;
  mag_t                 mags [MAX_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] samp [MAX_CHANNELS];
  emit_t                emit_r;

  logic [MAG_BITS+WID_BITS-1:0] prod;
  logic                 out_valid_r;
  logic [PIX_BITS-1:0]  x_r, y_r;
  logic                 last_r;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SAMPLE_COUNT, CFG_COLUMN_COUNT, CFG_PLOT_HEIGHT,
        CFG_CENTER_ROW, CFG_ORIGIN_COLUMN, CFG_CHANNEL_COUNT: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samples_r <= SIDX_BITS'(1);
      columns_r <= WID_BITS'(1);
      height_r  <= '0;
      center_r  <= '0;
      origin_r  <= '0;
      chans_r   <= 2'd1;
      start_r   <= 1'b0;
    end else begin
      start_r <= cfg_hit;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_SAMPLE_COUNT:  samples_r <= cfg_data[SIDX_BITS-1:0];
          CFG_COLUMN_COUNT:  columns_r <= cfg_data[WID_BITS-1:0];
          CFG_PLOT_HEIGHT:   height_r  <= cfg_data[WID_BITS-1:0];
          CFG_CENTER_ROW:    center_r  <= cfg_data[WID_BITS-1:0];
          CFG_ORIGIN_COLUMN: origin_r  <= cfg_data[WID_BITS-1:0];
          CFG_CHANNEL_COUNT: chans_r   <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    n_eff = (samples_r == '0) ? SIDX_BITS'(1) : samples_r;
    w_eff = (columns_r == '0) ? WID_BITS'(1) : columns_r;
    if (w_eff > WID_BITS'(MAX_COLUMNS)) w_eff = WID_BITS'(MAX_COLUMNS);
    if (SIDX_BITS'(w_eff) > n_eff) w_eff = n_eff[WID_BITS-1:0];
    ch_eff = (chans_r == '0) ? 2'd1 : chans_r;
    if (ch_eff > 2'(MAX_CHANNELS)) ch_eff = 2'(MAX_CHANNELS);
  end

  wcpp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (n_eff),
    .divisor  (w_eff),
    .busy     (div_busy),
    .quo      (quo),
    .rem      (rem)
  );

  assign o_adv    = !out_valid_r || !out_stall;
  assign e_free   = !emit_r.valid || o_adv;
  assign step     = l_valid_r && e_free;
  assign l_free   = !l_valid_r || step;
  assign in_stall = div_busy || start_r || cfg_hit || !l_free;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_valid_r <= 1'b0;
    end else if (l_free) begin
      l_valid_r <= in_acc;
    end
  end

  assign samp[0] = in_sample_ch0;
  assign samp[1] = in_sample_ch1;

  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
    wcpp_lane u_lane (
      .clk    (clk),
      .load   (in_acc),
      .active (2'(i) < ch_eff),
      .sample (samp[i]),
      .mag_r  (mags[i])
    );
  end

  wcpp_track u_track (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (cfg_hit),
    .step   (step),
    .e_free (e_free),
    .mags   (mags),
    .quo    (quo),
    .rem    (rem),
    .cols   (w_eff),
    .emit_r (emit_r)
  );

  assign prod = emit_r.peak * height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_adv) begin
      out_valid_r <= emit_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_adv) begin
      x_r    <= {origin_r[WID_BITS-1], origin_r} + {2'b00, emit_r.col};
      y_r    <= {center_r[WID_BITS-1], center_r}
                - {2'b00, prod[MAG_BITS+WID_BITS-1:16]};
      last_r <= emit_r.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = x_r;
  assign out_pixel_y     = y_r;
  assign out_last_column = last_r;

endmodule
`default_nettype wire

### tb/waveform_column_peak_plotter_tb.sv
// Self-checking testbench for waveform_column_peak_plotter: frames in, column peak pixels out.
// Predicts every pixel from its own register and clip state; needs wcpp_pkg and the block.
module waveform_column_peak_plotter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wcpp_pkg::*;

  localparam int CLK_PERIOD       = 10;
  localparam int QUIET_LIMIT      = 2000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int RANDOM_FRAMES    = 640;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] ch0;
    logic signed [SAMPLE_BITS-1:0] ch1;
  } frame_t;

  typedef struct packed {
    logic signed [PIX_BITS-1:0] x;
    logic signed [PIX_BITS-1:0] y;
    logic                       last;
  } pixel_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic signed [SAMPLE_BITS-1:0]  in_sample_ch0 = '0;
  logic signed [SAMPLE_BITS-1:0]  in_sample_ch1 = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic signed [PIX_BITS-1:0]     out_pixel_x;
  logic signed [PIX_BITS-1:0]     out_pixel_y;
  logic                           out_last_column;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [CFG_IDX_BITS-1:0]        cfg_index = '0;
  logic [CFG_DAT_BITS-1:0]        cfg_data = '0;

  waveform_column_peak_plotter DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_ch0   (in_sample_ch0),
    .in_sample_ch1   (in_sample_ch1),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_last_column (out_last_column),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  wire frame_txn = rst_n && in_valid && !in_stall;
  wire pixel_txn = rst_n && out_valid && !out_stall;
  wire reg_txn   = rst_n && cfg_valid && cfg_ready;

  frame_t      pending_frames[$];
  pixel_t      expected_pixels[$];
  logic        frame_was_taken = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        long_hold_on = 1'b0;
  event        long_hold_go;
  int unsigned quiet_cycles = 0;

  int unsigned frames_sent = 0;
  int unsigned pixels_checked = 0;
  int unsigned mismatches = 0;
  int unsigned config_writes = 0;
  int unsigned settings_used = 0;

  // plotter registers and clip state as the block should hold them
  logic [SIDX_BITS-1:0]   frames_reg;
  logic [WID_BITS-1:0]    cols_reg;
  logic [WID_BITS-1:0]    height_reg;
  logic signed [WID_BITS-1:0] center_reg;
  logic signed [WID_BITS-1:0] origin_reg;
  logic [1:0]             chans_reg;
  logic [SIDX_BITS-1:0]   clip_frame;
  int unsigned            clip_column;
  logic [SIDX_BITS-1:0]   column_end;
  int unsigned            column_rem;
  mag_t                   column_peak;

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic mag_t magnitude(input logic signed [SAMPLE_BITS-1:0] s);
    if (s == 16'sh8000) return '1;
    if (s < 0) return mag_t'(-s);
    return mag_t'(s);
  endfunction

  function automatic void clear_clip();
    clip_frame  = '0;
    clip_column = 0;
    column_end  = '0;
    column_rem  = 0;
    column_peak = '0;
  endfunction

  task automatic advance_column_end(input int unsigned n, input int unsigned w);
    column_end = column_end + (n / w);
    column_rem = column_rem + (n % w);
    if (column_rem >= w) begin
      column_rem = column_rem - w;
      column_end = column_end + 1'b1;
    end
  endtask

  task automatic plot_frame(input logic signed [SAMPLE_BITS-1:0] s0,
                            input logic signed [SAMPLE_BITS-1:0] s1);
    int unsigned n, w, ch, scaled;
    int          xv, yv;
    mag_t        m0, m1;
    pixel_t      px;
    n = (frames_reg == 0) ? 1 : frames_reg;
    w = (cols_reg == 0) ? 1 : cols_reg;
    if (w > MAX_COLUMNS) w = MAX_COLUMNS;
    if (w > n) w = n;
    ch = (chans_reg == 0) ? 1 : chans_reg;
    if (ch > MAX_CHANNELS) ch = MAX_CHANNELS;
    if (clip_frame == 0 && clip_column == 0) begin
      column_end = '0;
      column_rem = 0;
      advance_column_end(n, w);
    end
    m0 = magnitude(s0);
    m1 = magnitude(s1);
    if (m0 > column_peak) column_peak = m0;
    if (ch >= 2 && m1 > column_peak) column_peak = m1;
    clip_frame = clip_frame + 1'b1;
    if (clip_frame == column_end) begin
      scaled  = (32'(column_peak) * 32'(height_reg)) >> 16;
      xv      = int'(origin_reg) + int'(clip_column);
      yv      = int'(center_reg) - int'(scaled);
      px.x    = xv[PIX_BITS-1:0];
      px.y    = yv[PIX_BITS-1:0];
      px.last = (clip_column + 1 >= w);
      expected_pixels.push_back(px);
      column_peak = '0;
      if (px.last) begin
        clear_clip();
      end else begin
        clip_column++;
        advance_column_end(n, w);
      end
    end
  endtask

  // monitor: check results, then track register writes and accepted frames
  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      frames_reg = 1;
      cols_reg   = 1;
      height_reg = 0;
      center_reg = 0;
      origin_reg = 0;
      chans_reg  = 1;
      clear_clip();
      frame_was_taken <= 1'b0;
    end else begin
      if (pixel_txn) begin
        pixels_checked++;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected pixel: x=%0d y=%0d last=%0b",
                     out_pixel_x, out_pixel_y, out_last_column);
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_x !== want.x || out_pixel_y !== want.y ||
              out_last_column !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                       want.x, want.y, want.last, out_pixel_x, out_pixel_y, out_last_column);
          end
        end
      end
      if (reg_txn) begin
        case (cfg_index)
          CFG_SAMPLE_COUNT:  frames_reg = cfg_data[SIDX_BITS-1:0];
          CFG_COLUMN_COUNT:  cols_reg   = cfg_data[WID_BITS-1:0];
          CFG_PLOT_HEIGHT:   height_reg = cfg_data[WID_BITS-1:0];
          CFG_CENTER_ROW:    center_reg = cfg_data[WID_BITS-1:0];
          CFG_ORIGIN_COLUMN: origin_reg = cfg_data[WID_BITS-1:0];
          CFG_CHANNEL_COUNT: chans_reg  = cfg_data[1:0];
          default: ;
        endcase
        if (cfg_index <= CFG_CHANNEL_COUNT) clear_clip();
      end
      frame_was_taken <= frame_txn;
      if (frame_txn) begin
        frames_sent++;
        plot_frame(in_sample_ch0, in_sample_ch1);
      end
    end
  end

  // driver: hold a frame until taken, then advance or idle
  always @(negedge clk) begin
    frame_t f;
    if (!in_valid || frame_was_taken) begin
      if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        f = pending_frames.pop_front();
        in_valid      <= 1'b1;
        in_sample_ch0 <= f.ch0;
        in_sample_ch1 <= f.ch1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= long_hold_on || ($urandom_range(99) < recv_stall_pct);
  end

  always begin
    @(long_hold_go);
    long_hold_on = 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    long_hold_on = 1'b0;
  end

  always @(posedge clk) begin
    if (frame_txn || pixel_txn || reg_txn) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no transaction for %0d cycles", QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER:   begin send_idle_pct = 73; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 73; end
      IDLE_BOTH:     begin send_idle_pct = 29; recv_stall_pct = 29; end
      default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  task automatic send_frame(input logic signed [SAMPLE_BITS-1:0] s0,
                            input logic signed [SAMPLE_BITS-1:0] s1);
    frame_t f;
    f.ch0 = s0;
    f.ch1 = s1;
    pending_frames.push_back(f);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DAT_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    config_writes++;
  endtask

  task automatic wait_drained(input int unsigned settle);
    while (pending_frames.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2, 3:    return 16'($urandom_range(511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned n, w, h, count, random_sent;
    int          phase;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    set_idling(IDLE_NONE);

    // reset values: one-column clips of one frame
    send_frame(16'sh8000, 16'sh7fff);
    send_frame(16'sh1234, 16'sh8000);
    wait_drained(8);
    settings_used++;

    write_reg(CFG_SAMPLE_COUNT, 24'd5);
    write_reg(CFG_COLUMN_COUNT, 24'd3);
    write_reg(CFG_PLOT_HEIGHT, 24'hFFFFFF);
    write_reg(CFG_CENTER_ROW, 24'h000FFF);
    write_reg(CFG_ORIGIN_COLUMN, 24'hFFF000);
    write_reg(CFG_CHANNEL_COUNT, 24'h000002);
    send_frame(16'sh8000, 16'sh0000);
    send_frame(16'sh0000, 16'sh8000);
    send_frame(16'sh7fff, 16'sh0001);
    send_frame(16'shffff, 16'shffff);
    send_frame(16'sh0000, 16'sh0000);
    wait_drained(8);
    settings_used++;

    // single channel: ch1 ignored
    write_reg(CFG_CHANNEL_COUNT, 24'hFFFFFD);
    write_reg(CFG_SAMPLE_COUNT, 24'd2);
    write_reg(CFG_COLUMN_COUNT, 24'd2);
    send_frame(16'sh0000, 16'sh8000);
    send_frame(16'sh0100, 16'sh7fff);
    wait_drained(8);
    settings_used++;

    // zero sample and column counts, channel count above two
    write_reg(CFG_SAMPLE_COUNT, 24'd0);
    write_reg(CFG_COLUMN_COUNT, 24'd0);
    write_reg(CFG_CENTER_ROW, 24'h001000);
    write_reg(CFG_ORIGIN_COLUMN, 24'h000FFF);
    write_reg(CFG_CHANNEL_COUNT, 24'd3);
    send_frame(16'sh0000, 16'sh8000);
    send_frame(16'sh0001, 16'sh0000);
    wait_drained(8);
    settings_used++;

    // column count far above sample count, zero channels
    write_reg(CFG_SAMPLE_COUNT, 24'd3);
    write_reg(CFG_COLUMN_COUNT, 24'h001FFF);
    write_reg(CFG_CHANNEL_COUNT, 24'd0);
    send_frame(16'sh0000, 16'sh8000);
    send_frame(16'shffff, 16'sh7fff);
    send_frame(16'sh0002, 16'sh8000);
    wait_drained(8);
    settings_used++;

    // a write in mid clip restarts it
    write_reg(CFG_SAMPLE_COUNT, 24'd4);
    write_reg(CFG_COLUMN_COUNT, 24'd1);
    send_frame(16'sh7fff, 16'sh7fff);
    send_frame(16'sh7fff, 16'sh7fff);
    wait_drained(8);
    write_reg(CFG_CENTER_ROW, 24'd0);
    send_frame(16'sh0010, 16'sh0000);
    send_frame(-16'sd32, 16'sh0000);
    send_frame(16'sh0008, 16'sh0000);
    send_frame(16'sh0000, 16'sh0000);
    wait_drained(8);

    // writes to unused indexes leave the clip running
    send_frame(-16'sd300, 16'sh0000);
    wait_drained(8);
    write_reg(CFG_SPARE_LO, 24'($urandom));
    write_reg(CFG_SPARE_HI, 24'($urandom));
    send_frame(16'sh000a, 16'sh7fff);
    send_frame(16'sh0000, 16'sh0000);
    send_frame(16'sh0005, 16'sh8000);
    wait_drained(8);
    settings_used++;

    // hold the result side off so the block backs up into its input
    write_reg(CFG_SAMPLE_COUNT, 24'd64);
    write_reg(CFG_COLUMN_COUNT, 24'd64);
    write_reg(CFG_PLOT_HEIGHT, 24'd2048);
    write_reg(CFG_ORIGIN_COLUMN, 24'($urandom));
    write_reg(CFG_CHANNEL_COUNT, 24'd2);
    for (int i = 0; i < 200; i++) send_frame(random_sample(), random_sample());
    -> long_hold_go;
    wait_drained(8);
    settings_used++;

    // long columns: first closes after 511 frames, second carries the remainder
    set_idling(IDLE_BOTH);
    write_reg(CFG_SAMPLE_COUNT, 24'h1FFFFF);
    write_reg(CFG_COLUMN_COUNT, 24'd4096);
    write_reg(CFG_PLOT_HEIGHT, 24'd4096);
    write_reg(CFG_CENTER_ROW, 24'($urandom));
    for (int i = 0; i < 1023; i++) send_frame(random_sample(), random_sample());
    wait_drained(8);
    settings_used++;

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_FRAMES) begin
      set_idling(idle_mode_t'(phase % 4));
      n = ($urandom_range(3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 300);
      case ($urandom_range(7))
        0:       w = $urandom_range(n + 1, 8191);
        1:       w = 0;
        2:       w = n;
        default: w = $urandom_range(1, n);
      endcase
      case ($urandom_range(3))
        0:       h = 0;
        1:       h = 8191;
        default: h = $urandom_range(8191);
      endcase
      write_reg(CFG_SAMPLE_COUNT, ($urandom_range(19) == 0) ? 24'd0 : 24'(n));
      write_reg(CFG_COLUMN_COUNT, {11'($urandom), 13'(w)});
      write_reg(CFG_PLOT_HEIGHT, {11'($urandom), 13'(h)});
      write_reg(CFG_CENTER_ROW, 24'($urandom));
      write_reg(CFG_ORIGIN_COLUMN, 24'($urandom));
      write_reg(CFG_CHANNEL_COUNT, {22'($urandom), 2'($urandom_range(3))});
      if ($urandom_range(5) == 0)
        write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, 24'($urandom));
      count = $urandom_range(40, 220);
      for (int i = 0; i < count; i++) begin
        send_frame(random_sample(), random_sample());
        if (phase % 5 == 2 && i == count / 2) wait_drained(0);
      end
      wait_drained(8);
      random_sent += count;
      settings_used++;
      phase++;
    end

    $display("Run covered %0d frames under %0d register settings (%0d register writes).",
             frames_sent, settings_used, config_writes);
    $display("Compared %0d plotted columns; %0d mismatches.", pixels_checked, mismatches);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### files.f
rtl/wcpp_pkg.sv
rtl/wcpp_lane.sv
rtl/wcpp_div.sv
rtl/wcpp_track.sv
rtl/waveform_column_peak_plotter.sv
tb/waveform_column_peak_plotter_tb.sv
